// ===== hdl/signed_int_to_decimal_ascii_core_macros.svh =====
// Assertion macros for the converter RTL, used by itoa_serial.
// ITOA_ASSERT_SAME: antecedent implies consequent in the same cycle.
// ITOA_ASSERT_NEXT: antecedent implies consequent in the next cycle.
// Both expect clk and rst in scope and are disabled while rst is high.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define ITOA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("converter assertion failed");
`define ITOA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("converter assertion failed");
`else
`define ITOA_ASSERT_SAME(label, ante, cons)
`define ITOA_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hdl/itoa_pkg.sv =====
`timescale 1ns / 1ps

package itoa_pkg;

  // ASCII codes, 6 bits wide
  localparam logic [5:0] CHAR_ZERO  = 6'd48;
  localparam logic [5:0] CHAR_MINUS = 6'd45;

  // width of the leading-digit index carried down the pipeline
  localparam int LEAD_W = 4;

  // per-item control carried alongside the remainder
  typedef struct packed {
    logic              neg;      // value was negative
    logic              started;  // first printed digit found
    logic [LEAD_W-1:0] lead;     // index of first printed digit
  } ctl_t;

  // 10^n at elaboration time
  function automatic logic [63:0] pow10(input int n);
    logic [63:0] p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // decimal digits needed for the magnitude 2^(w-1)
  function automatic int num_digits(input int w);
    logic [63:0] v;
    int          n;
    v = 64'd1 << (w - 1);
    n = 0;
    for (int i = 0; i < 20; i++) begin
      if (v != 64'd0) begin
        v = v / 64'd10;
        n++;
      end
    end
    return n;
  endfunction

endpackage

// ===== hdl/signed_int_to_decimal_ascii_core.sv =====
`timescale 1ns / 1ps
// Signed integer to decimal ASCII converter.
// Input channel s_*: one item per signed integer in s_tdata (low VW bits used,
// VW being VALUE_WIDTH clamped to 8..32; bit VW-1 is the sign). Output channel m_*: one item per
// character, m_tdata[5:0] holds the ASCII code and m_tlast marks the final
// character of each number. Negative numbers start with '-', leading zeros are
// dropped, zero prints as a single '0'.
// Pipeline: one register for sign/magnitude, then one stage per decimal digit
// (10 at the default width), each doing a parallel compare against k*10^n and
// one subtract. m_tvalid for the first character rises once the item has passed
// the sign/magnitude register, the digit stages and the output register.
// Throughput is set by the output: one character per cycle while m_tready is
// high; numbers of 1 to 11 characters go back to back with no gap between them.
// A new input item enters whenever the pipeline can move; the pipeline moves
// when its head is empty or the head's last character is loaded.
// When m_tready is low the output register holds and the pipeline stalls once
// its head holds an item; nothing is dropped or repeated. Reset (rst,
// synchronous) empties every stage and the output register.

module signed_int_to_decimal_ascii_core
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
  output logic        m_tlast    // last_char
);

  localparam int VW   = (VALUE_WIDTH < 8) ? 8 : ((VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH);
  localparam int NDIG = num_digits(VW);

  logic              adv;
  logic              pop;
  logic [VW-1:0]     raw;
  logic              vld  [0:NDIG];
  ctl_t              ctl  [0:NDIG];
  logic [VW-1:0]     rem  [0:NDIG];
  logic [NDIG*4-1:0] digs [0:NDIG];
  logic [5:0]        char_code;

  assign adv      = !vld[NDIG] || pop;
  assign s_tready = adv;
  assign raw      = s_tdata[VW-1:0];

  // front stage: sign and magnitude; negation of the most negative value
  // wraps to 2^(VW-1), which is the magnitude wanted
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (adv) begin
      vld[0] <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ctl[0].neg     <= raw[VW-1];
      ctl[0].started <= 1'b0;
      ctl[0].lead    <= '0;
      rem[0]         <= raw[VW-1] ? (~raw + VW'(1)) : raw;
      digs[0]        <= '0;
    end
  end

  // one stage per decimal digit, most significant first
  for (genvar g = 0; g < NDIG; g++) begin : g_digit
    itoa_digit_stage #(
      .MAG_W (VW),
      .NDIG  (NDIG),
      .IDX   (g)
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .en       (adv),
      .in_vld   (vld[g]),
      .in_ctl   (ctl[g]),
      .in_rem   (rem[g]),
      .in_digs  (digs[g]),
      .out_vld  (vld[g+1]),
      .out_ctl  (ctl[g+1]),
      .out_rem  (rem[g+1]),
      .out_digs (digs[g+1])
    );
  end

  // character serializer with output register
  itoa_serial #(
    .NDIG (NDIG)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .head_vld  (vld[NDIG]),
    .head_ctl  (ctl[NDIG]),
    .head_digs (digs[NDIG]),
    .pop       (pop),
    .out_vld   (m_tvalid),
    .out_rdy   (m_tready),
    .out_code  (char_code),
    .out_last  (m_tlast)
  );

  assign m_tdata = {2'b00, char_code};

endmodule

// ===== hdl/itoa_digit_stage.sv =====
`timescale 1ns / 1ps

module itoa_digit_stage
  import itoa_pkg::*;
#(
  parameter int MAG_W = 32,
  parameter int NDIG  = 10,
  parameter int IDX   = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_vld,
  input  ctl_t              in_ctl,
  input  logic [MAG_W-1:0]  in_rem,
  input  logic [NDIG*4-1:0] in_digs,
  output logic              out_vld,
  output ctl_t              out_ctl,
  output logic [MAG_W-1:0]  out_rem,
  output logic [NDIG*4-1:0] out_digs
);

  localparam int          EXT_W = MAG_W + 4;
  localparam logic [63:0] DIV   = pow10(NDIG - 1 - IDX);

  logic [EXT_W-1:0]  ext;
  logic [EXT_W-1:0]  sub;
  logic [EXT_W-1:0]  mk;
  logic [3:0]        digit;
  logic [MAG_W-1:0]  rem_next;
  ctl_t              ctl_next;
  logic [NDIG*4-1:0] digs_next;

  // digit = largest k with k*DIV <= remainder; compares run in parallel
  always_comb begin
    ext   = {4'b0, in_rem};
    digit = 4'd0;
    sub   = '0;
    mk    = '0;
    for (int k = 1; k < 10; k++) begin
      mk = EXT_W'(64'(k) * DIV);
      if (ext >= mk) begin
        digit = 4'(k);
        sub   = mk;
      end
    end
    rem_next = MAG_W'(ext - sub);
  end

  // first nonzero digit (or the units digit for zero) marks the lead
  always_comb begin
    ctl_next  = in_ctl;
    digs_next = in_digs;
    digs_next[IDX*4 +: 4] = digit;
    if (!in_ctl.started && (digit != 4'd0 || IDX == NDIG - 1)) begin
      ctl_next.started = 1'b1;
      ctl_next.lead    = LEAD_W'(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ctl  <= ctl_next;
      out_rem  <= rem_next;
      out_digs <= digs_next;
    end
  end

endmodule

// ===== hdl/itoa_serial.sv =====
`timescale 1ns / 1ps
`include "signed_int_to_decimal_ascii_core_macros.svh"

module itoa_serial
  import itoa_pkg::*;
#(
  parameter int NDIG = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_vld,
  input  ctl_t              head_ctl,
  input  logic [NDIG*4-1:0] head_digs,
  output logic              pop,
  output logic              out_vld,
  input  logic              out_rdy,
  output logic [5:0]        out_code,
  output logic              out_last
);

  localparam int IW = $clog2(NDIG);

  logic          sign_done;
  logic          mid;
  logic [IW-1:0] pos;
  logic [IW-1:0] eff;
  logic          load;
  logic          emit_minus;
  logic          is_last;
  logic [3:0]    digit;

  // pick the next character of the item at the pipeline head
  always_comb begin
    load       = head_vld && (!out_vld || out_rdy);
    eff        = mid ? pos : head_ctl.lead[IW-1:0];
    emit_minus = head_ctl.neg && !sign_done;
    digit      = head_digs[eff*4 +: 4];
    is_last    = !emit_minus && (eff == IW'(NDIG - 1));
    pop        = load && is_last;
  end

  // character walk state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld   <= 1'b0;
      sign_done <= 1'b0;
      mid       <= 1'b0;
    end else begin
      if (load) begin
        out_vld <= 1'b1;
      end else if (out_rdy) begin
        out_vld <= 1'b0;
      end
      if (load) begin
        if (emit_minus) begin
          sign_done <= 1'b1;
        end else if (is_last) begin
          sign_done <= 1'b0;
          mid       <= 1'b0;
        end else begin
          mid <= 1'b1;
        end
      end
    end
  end

  // output register and digit pointer
  always_ff @(posedge clk) begin
    if (load) begin
      out_code <= emit_minus ? CHAR_MINUS : (CHAR_ZERO + {2'b0, digit});
      out_last <= is_last;
      if (!emit_minus && !is_last) begin
        pos <= eff + IW'(1);
      end
    end
  end

  `ITOA_ASSERT_SAME(a_code_range, out_vld, out_code == CHAR_MINUS || (out_code >= CHAR_ZERO && out_code <= CHAR_ZERO + 6'd9))
  `ITOA_ASSERT_SAME(a_minus_not_last, out_vld && out_code == CHAR_MINUS, !out_last)
  `ITOA_ASSERT_NEXT(a_walk_cleared, pop, !mid && !sign_done && out_vld && out_last)

endmodule
